// ===== src/pc_sample_block_histogram_defines.svh =====
// Assertion macros shared by the histogram RTL.
`ifndef PC_SAMPLE_BLOCK_HISTOGRAM_DEFINES_SVH
`define PC_SAMPLE_BLOCK_HISTOGRAM_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define PSBH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("psbh assertion failed");
// Check a property on every rising edge, reset included.
`define PSBH_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("psbh assertion failed");
`else
`define PSBH_ASSERT(label, clk, rst_n, prop)
`define PSBH_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== src/psbh_pkg.sv =====
// Types, sizes and codes of the sampled-PC block histogram.
package psbh_pkg;

    localparam int SLOTS       = 32;
    localparam int MAX_DUMP    = 32;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W      = $clog2(SLOTS + 1);
    localparam int PC_W        = 64;
    localparam int BLOCK_SHIFT = 6;
    localparam int KEY_W       = PC_W - BLOCK_SHIFT;
    localparam int CNT_W       = 32;
    localparam int SLOT_W      = 5;
    localparam int USED_W      = 6;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_DUMP   = 1'b1;

    typedef enum logic [1:0] {
        KIND_RECORD  = 2'd0,
        KIND_ENTRY   = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_NEW  = 2'd1,
        ST_DROP = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MISS,
        S_SUM
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] gc;
        logic [CNT_W-1:0] ee;
    } t_slot_entry;

    // Add a one-bit increment and hold at all ones instead of wrapping.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a,
                                                 input logic b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{CNT_W{1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// ===== src/psbh_in_if.sv =====
// Input channel: one sampled PC or a dump request.
interface psbh_in_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [psbh_pkg::PC_W-1:0]       pc;
    logic                            in_gc;
    logic                            in_ee;

    modport source (output valid, action, pc, in_gc, in_ee, input ready);
    modport sink   (input valid, action, pc, in_gc, in_ee, output ready);
endinterface

// ===== src/psbh_out_if.sv =====
// Output channel: record status, table entries and dump summary.
interface psbh_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      kind;
    logic [1:0]                      status;
    logic [psbh_pkg::SLOT_W-1:0]     slot;
    logic [psbh_pkg::KEY_W-1:0]      block_key;
    logic [psbh_pkg::CNT_W-1:0]      sample_count;
    logic [psbh_pkg::CNT_W-1:0]      gc_count;
    logic [psbh_pkg::CNT_W-1:0]      ee_count;
    logic [psbh_pkg::CNT_W-1:0]      dropped_count;
    logic [psbh_pkg::USED_W-1:0]     used_slots;
    logic                            is_last;

    modport source (output valid, kind, status, slot, block_key, sample_count,
                    gc_count, ee_count, dropped_count, used_slots, is_last,
                    input ready);
    modport sink   (input valid, kind, status, slot, block_key, sample_count,
                    gc_count, ee_count, dropped_count, used_slots, is_last,
                    output ready);
endinterface

// ===== src/psbh_slot_ram.sv =====
// Single-write, single-read RAM with registered read data.
module psbh_slot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/pc_sample_block_histogram.sv =====
// Associative histogram of sampled program-counter blocks, top level.
//
// Each record transfer reduces the PC to its 64-byte block and walks the
// filled slots one per cycle through a one-read, one-write slot RAM, comparing
// the stored key and, on a hit, updating the three saturating counters in one
// step before writing the slot back. A miss appends a slot while
// room remains, else the saturating drop counter advances. Every record gives
// exactly one result transfer. A dump transfer gives one entry per used slot
// in slot order (at most 32) and then a summary carrying the drop count.
// A record passes the accept step, a scan step per slot visited and, on a
// miss, an append or drop step; a dump passes the accept step, a scan step per
// used slot and a summary step. The rate is set by the slot RAM, which gives
// one entry per cycle; a dump entry or a hit waits on a full output register.
// Input ready is high only while the sequencer idles; one output register
// holds a finished result, so a new transfer is accepted while it still waits.
// Slot RAM contents are undefined after reset and need no clearing: only
// slots below the fill count are ever read.
`include "pc_sample_block_histogram_defines.svh"

module pc_sample_block_histogram (
    input  logic            i_clk,
    input  logic            i_rst_n,
    psbh_in_if.sink         i_in,
    psbh_out_if.source      o_out
);

    // Sequencer state and captured item.
    psbh_pkg::t_state                   r_state, n_state;
    logic [psbh_pkg::IDX_W-1:0]         r_idx, n_idx;
    logic [psbh_pkg::FILL_W-1:0]        r_fill, n_fill;
    logic [psbh_pkg::CNT_W-1:0]         r_drops, n_drops;
    logic                               r_action, n_action;
    logic [psbh_pkg::KEY_W-1:0]         r_key, n_key;
    logic                               r_gc, n_gc;
    logic                               r_ee, n_ee;

    // Output register.
    logic                               r_out_valid, n_out_valid;
    logic [1:0]                         r_out_kind, n_out_kind;
    logic [1:0]                         r_out_status, n_out_status;
    logic [psbh_pkg::SLOT_W-1:0]        r_out_slot, n_out_slot;
    logic [psbh_pkg::KEY_W-1:0]         r_out_key, n_out_key;
    logic [psbh_pkg::CNT_W-1:0]         r_out_cnt, n_out_cnt;
    logic [psbh_pkg::CNT_W-1:0]         r_out_gc, n_out_gc;
    logic [psbh_pkg::CNT_W-1:0]         r_out_ee, n_out_ee;
    logic [psbh_pkg::CNT_W-1:0]         r_out_drops, n_out_drops;
    logic [psbh_pkg::USED_W-1:0]        r_out_used, n_out_used;
    logic                               r_out_last, n_out_last;

    // Slot RAM port signals.
    logic                               ram_we;
    logic [psbh_pkg::IDX_W-1:0]         ram_waddr;
    psbh_pkg::t_slot_entry              ram_wdata;
    psbh_pkg::t_slot_entry              ram_rdata;
    logic [$bits(psbh_pkg::t_slot_entry)-1:0] ram_rdata_bits;

    // Shared compare / update unit and sequencer helpers.
    logic                               in_xfer;
    logic                               out_free;
    logic                               key_hit;
    logic                               idx_last;
    logic                               dump_stop;
    logic [psbh_pkg::FILL_W-1:0]        idx_ext;
    psbh_pkg::t_slot_entry              upd_entry;

    psbh_slot_ram #(
        .WIDTH ($bits(psbh_pkg::t_slot_entry)),
        .DEPTH (psbh_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata_bits)
    );

    assign ram_rdata = psbh_pkg::t_slot_entry'(ram_rdata_bits);

    assign in_xfer  = i_in.valid && i_in.ready;
    // The output register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || o_out.ready;

    // Read data always belongs to r_idx: the RAM is addressed with n_idx.
    assign key_hit  = (ram_rdata.key == r_key);
    assign idx_ext  = psbh_pkg::FILL_W'(r_idx);
    assign idx_last = ((idx_ext + psbh_pkg::FILL_W'(1)) == r_fill);
    assign dump_stop = idx_last ||
                       (idx_ext == psbh_pkg::FILL_W'(psbh_pkg::MAX_DUMP - 1));

    always_comb begin
        upd_entry.key = ram_rdata.key;
        upd_entry.cnt = psbh_pkg::sat_inc(ram_rdata.cnt, 1'b1);
        upd_entry.gc  = psbh_pkg::sat_inc(ram_rdata.gc, r_gc);
        upd_entry.ee  = psbh_pkg::sat_inc(ram_rdata.ee, r_ee);
    end

    assign i_in.ready = (r_state == psbh_pkg::S_IDLE);

    // Next state, table updates and result loading.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_fill       = r_fill;
        n_drops      = r_drops;
        n_action     = r_action;
        n_key        = r_key;
        n_gc         = r_gc;
        n_ee         = r_ee;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_key    = r_out_key;
        n_out_cnt    = r_out_cnt;
        n_out_gc     = r_out_gc;
        n_out_ee     = r_out_ee;
        n_out_drops  = r_out_drops;
        n_out_used   = r_out_used;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = upd_entry;

        unique case (r_state)
            psbh_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_action = i_in.action;
                    n_key    = i_in.pc[psbh_pkg::PC_W-1:psbh_pkg::BLOCK_SHIFT];
                    n_gc     = i_in.in_gc;
                    n_ee     = i_in.in_ee;
                    n_idx    = '0;
                    if (r_fill == '0) begin
                        n_state = (i_in.action == psbh_pkg::ACT_DUMP) ?
                                  psbh_pkg::S_SUM : psbh_pkg::S_MISS;
                    end else begin
                        n_state = psbh_pkg::S_SCAN;
                    end
                end
            end

            psbh_pkg::S_SCAN: begin
                if (r_action == psbh_pkg::ACT_DUMP) begin
                    // Emit the current slot, then advance or finish.
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = psbh_pkg::KIND_ENTRY;
                        n_out_status = psbh_pkg::ST_HIT;
                        n_out_slot   = psbh_pkg::SLOT_W'(r_idx);
                        n_out_key    = ram_rdata.key;
                        n_out_cnt    = ram_rdata.cnt;
                        n_out_gc     = ram_rdata.gc;
                        n_out_ee     = ram_rdata.ee;
                        n_out_drops  = r_drops;
                        n_out_used   = psbh_pkg::USED_W'(r_fill);
                        n_out_last   = 1'b0;
                        if (dump_stop) begin
                            n_state = psbh_pkg::S_SUM;
                        end else begin
                            n_idx = r_idx + psbh_pkg::IDX_W'(1);
                        end
                    end
                end else if (key_hit) begin
                    // Hit: write the updated counters back and report.
                    if (out_free) begin
                        ram_we       = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out_kind   = psbh_pkg::KIND_RECORD;
                        n_out_status = psbh_pkg::ST_HIT;
                        n_out_slot   = psbh_pkg::SLOT_W'(r_idx);
                        n_out_key    = r_key;
                        n_out_cnt    = upd_entry.cnt;
                        n_out_gc     = upd_entry.gc;
                        n_out_ee     = upd_entry.ee;
                        n_out_drops  = r_drops;
                        n_out_used   = psbh_pkg::USED_W'(r_fill);
                        n_out_last   = 1'b1;
                        n_state      = psbh_pkg::S_IDLE;
                    end
                end else if (idx_last) begin
                    n_state = psbh_pkg::S_MISS;
                end else begin
                    n_idx = r_idx + psbh_pkg::IDX_W'(1);
                end
            end

            psbh_pkg::S_MISS: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = psbh_pkg::KIND_RECORD;
                    n_out_key    = r_key;
                    n_out_last   = 1'b1;
                    n_state      = psbh_pkg::S_IDLE;
                    if (r_fill < psbh_pkg::FILL_W'(psbh_pkg::SLOTS)) begin
                        // Append a fresh slot at the fill point.
                        ram_we        = 1'b1;
                        ram_waddr     = r_fill[psbh_pkg::IDX_W-1:0];
                        ram_wdata.key = r_key;
                        ram_wdata.cnt = psbh_pkg::CNT_W'(1);
                        ram_wdata.gc  = psbh_pkg::CNT_W'(r_gc);
                        ram_wdata.ee  = psbh_pkg::CNT_W'(r_ee);
                        n_fill        = r_fill + psbh_pkg::FILL_W'(1);
                        n_out_status  = psbh_pkg::ST_NEW;
                        n_out_slot    = psbh_pkg::SLOT_W'(r_fill);
                        n_out_cnt     = psbh_pkg::CNT_W'(1);
                        n_out_gc      = psbh_pkg::CNT_W'(r_gc);
                        n_out_ee      = psbh_pkg::CNT_W'(r_ee);
                        n_out_drops   = r_drops;
                        n_out_used    = psbh_pkg::USED_W'(n_fill);
                    end else begin
                        // Table full: count the drop.
                        n_drops      = psbh_pkg::sat_inc(r_drops, 1'b1);
                        n_out_status = psbh_pkg::ST_DROP;
                        n_out_slot   = '0;
                        n_out_cnt    = '0;
                        n_out_gc     = '0;
                        n_out_ee     = '0;
                        n_out_drops  = n_drops;
                        n_out_used   = psbh_pkg::USED_W'(r_fill);
                    end
                end
            end

            psbh_pkg::S_SUM: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = psbh_pkg::KIND_SUMMARY;
                    n_out_status = psbh_pkg::ST_HIT;
                    n_out_slot   = '0;
                    n_out_key    = '0;
                    n_out_cnt    = '0;
                    n_out_gc     = '0;
                    n_out_ee     = '0;
                    n_out_drops  = r_drops;
                    n_out_used   = psbh_pkg::USED_W'(r_fill);
                    n_out_last   = 1'b1;
                    n_state      = psbh_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = psbh_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psbh_pkg::S_IDLE;
            r_fill      <= '0;
            r_drops     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_drops     <= n_drops;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_action     <= n_action;
        r_key        <= n_key;
        r_gc         <= n_gc;
        r_ee         <= n_ee;
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_key    <= n_out_key;
        r_out_cnt    <= n_out_cnt;
        r_out_gc     <= n_out_gc;
        r_out_ee     <= n_out_ee;
        r_out_drops  <= n_out_drops;
        r_out_used   <= n_out_used;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out_kind;
    assign o_out.status        = r_out_status;
    assign o_out.slot          = r_out_slot;
    assign o_out.block_key     = r_out_key;
    assign o_out.sample_count  = r_out_cnt;
    assign o_out.gc_count      = r_out_gc;
    assign o_out.ee_count      = r_out_ee;
    assign o_out.dropped_count = r_out_drops;
    assign o_out.used_slots    = r_out_used;
    assign o_out.is_last       = r_out_last;

    // Fill count never passes the table size.
    `PSBH_ASSERT(a_fill_bound, i_clk, i_rst_n,
        r_fill <= psbh_pkg::FILL_W'(psbh_pkg::SLOTS))

    // A hit or new-slot result always names a slot that is in use.
    `PSBH_ASSERT(a_slot_in_use, i_clk, i_rst_n,
        (r_out_valid && r_out_kind == psbh_pkg::KIND_RECORD &&
         r_out_status != psbh_pkg::ST_DROP) |-> (r_out_slot < r_out_used))

    // Drops are counted only while the table is full.
    `PSBH_ASSERT(a_drop_when_full, i_clk, i_rst_n,
        ($past(i_rst_n) && r_drops != $past(r_drops)) |->
        ($past(r_fill) == psbh_pkg::FILL_W'(psbh_pkg::SLOTS)))

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the sampled-PC block histogram: directed table, then random load.
`timescale 1ns / 1ps

module testbench;

    localparam int  HALF_PERIOD  = 10;
    localparam int  RESET_CYCLES = 12;
    // The worst case for a result is a record that walks a full table.
    localparam int  DRAIN_CYCLES = psbh_pkg::SLOTS + 8;
    localparam int  HOT_BLOCKS   = 48;
    localparam int  PHASE_ITEMS  = 110;
    // A dump on a full table gives 33 transfers; even if every item were one,
    // with heavy stalls on the output side, the run stays far below this.
    localparam time TIMEOUT_NS   = 64'd10_000_000;

    // One item on the input channel.
    typedef struct packed {
        logic                       action;
        logic [psbh_pkg::PC_W-1:0]  pc;
        logic                       in_gc;
        logic                       in_ee;
    } t_sample;

    // One transfer on the output channel.
    typedef struct packed {
        psbh_pkg::t_kind              kind;
        psbh_pkg::t_status            status;
        logic [psbh_pkg::SLOT_W-1:0]  slot;
        logic [psbh_pkg::KEY_W-1:0]   block_key;
        logic [psbh_pkg::CNT_W-1:0]   sample_count;
        logic [psbh_pkg::CNT_W-1:0]   gc_count;
        logic [psbh_pkg::CNT_W-1:0]   ee_count;
        logic [psbh_pkg::CNT_W-1:0]   dropped_count;
        logic [psbh_pkg::USED_W-1:0]  used_slots;
        logic                         is_last;
    } t_hist_result;

    // One row of the directed table; typed rows carry the result to expect.
    typedef struct {
        t_sample       sample;
        bit            typed;
        t_hist_result  want;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;

    psbh_in_if  in_if ();
    psbh_out_if out_if ();

    pc_sample_block_histogram i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow copy of the histogram table, advanced once per accepted item.
    logic [psbh_pkg::KEY_W-1:0]  shadow_key [psbh_pkg::SLOTS];
    logic [psbh_pkg::CNT_W-1:0]  shadow_cnt [psbh_pkg::SLOTS];
    logic [psbh_pkg::CNT_W-1:0]  shadow_gc  [psbh_pkg::SLOTS];
    logic [psbh_pkg::CNT_W-1:0]  shadow_ee  [psbh_pkg::SLOTS];
    int                          shadow_fill;
    logic [psbh_pkg::CNT_W-1:0]  shadow_drops;

    // Results still owed by the block, oldest first.
    t_hist_result      owed_results [$];

    int                err_count;
    int                src_idle_pct;
    int                sink_stall_pct;

    logic [psbh_pkg::KEY_W-1:0]  hot_blocks [HOT_BLOCKS];
    t_plan_row                   plan [$];

    // Free-running clock.
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Hold the counter at all ones instead of wrapping.
    function automatic logic [psbh_pkg::CNT_W-1:0] sat_bump(
        input logic [psbh_pkg::CNT_W-1:0] a, input logic b);
        return (a == {psbh_pkg::CNT_W{1'b1}}) ? a : a + psbh_pkg::CNT_W'(b);
    endfunction

    function automatic t_hist_result result_of(
        input psbh_pkg::t_kind k, input psbh_pkg::t_status st,
        input logic [psbh_pkg::SLOT_W-1:0] sl,
        input logic [psbh_pkg::KEY_W-1:0] key, input logic [psbh_pkg::CNT_W-1:0] n,
        input logic [psbh_pkg::CNT_W-1:0] g, input logic [psbh_pkg::CNT_W-1:0] e,
        input logic [psbh_pkg::CNT_W-1:0] drops, input logic [psbh_pkg::USED_W-1:0] used,
        input logic last);
        t_hist_result r;
        r.kind          = k;
        r.status        = st;
        r.slot          = sl;
        r.block_key     = key;
        r.sample_count  = n;
        r.gc_count      = g;
        r.ee_count      = e;
        r.dropped_count = drops;
        r.used_slots    = used;
        r.is_last       = last;
        return r;
    endfunction

    // Apply one item to the shadow table and list the transfers it causes.
    task automatic histogram_step(input t_sample s, output t_hist_result res[$]);
        logic [psbh_pkg::KEY_W-1:0] key;
        int                         hit;
        res = {};
        if (s.action == psbh_pkg::ACT_RECORD) begin
            key = s.pc[psbh_pkg::PC_W-1:psbh_pkg::BLOCK_SHIFT];
            hit = -1;
            for (int i = 0; i < shadow_fill; i++) begin
                if (hit < 0 && shadow_key[i] == key) hit = i;
            end
            if (hit >= 0) begin
                shadow_cnt[hit] = sat_bump(shadow_cnt[hit], 1'b1);
                shadow_gc[hit]  = sat_bump(shadow_gc[hit], s.in_gc);
                shadow_ee[hit]  = sat_bump(shadow_ee[hit], s.in_ee);
                res.push_back(result_of(psbh_pkg::KIND_RECORD, psbh_pkg::ST_HIT,
                                        psbh_pkg::SLOT_W'(hit), key,
                                        shadow_cnt[hit], shadow_gc[hit], shadow_ee[hit],
                                        shadow_drops, psbh_pkg::USED_W'(shadow_fill), 1'b1));
            end else if (shadow_fill < psbh_pkg::SLOTS) begin
                shadow_key[shadow_fill] = key;
                shadow_cnt[shadow_fill] = 1;
                shadow_gc[shadow_fill]  = psbh_pkg::CNT_W'(s.in_gc);
                shadow_ee[shadow_fill]  = psbh_pkg::CNT_W'(s.in_ee);
                shadow_fill++;
                res.push_back(result_of(psbh_pkg::KIND_RECORD, psbh_pkg::ST_NEW,
                                        psbh_pkg::SLOT_W'(shadow_fill - 1), key,
                                        1, psbh_pkg::CNT_W'(s.in_gc),
                                        psbh_pkg::CNT_W'(s.in_ee),
                                        shadow_drops, psbh_pkg::USED_W'(shadow_fill), 1'b1));
            end else begin
                // Table full: count the drop, report the block that was lost.
                shadow_drops = sat_bump(shadow_drops, 1'b1);
                res.push_back(result_of(psbh_pkg::KIND_RECORD, psbh_pkg::ST_DROP, '0, key,
                                        '0, '0, '0,
                                        shadow_drops, psbh_pkg::USED_W'(shadow_fill), 1'b1));
            end
        end else begin
            for (int i = 0; i < shadow_fill && i < psbh_pkg::MAX_DUMP; i++) begin
                res.push_back(result_of(psbh_pkg::KIND_ENTRY, psbh_pkg::ST_HIT,
                                        psbh_pkg::SLOT_W'(i), shadow_key[i],
                                        shadow_cnt[i], shadow_gc[i], shadow_ee[i],
                                        shadow_drops, psbh_pkg::USED_W'(shadow_fill), 1'b0));
            end
            res.push_back(result_of(psbh_pkg::KIND_SUMMARY, psbh_pkg::ST_HIT,
                                    '0, '0, '0, '0, '0,
                                    shadow_drops, psbh_pkg::USED_W'(shadow_fill), 1'b1));
        end
    endtask

    // Offer one item, with random idle cycles ahead of it, and book its results
    // once the transfer has happened.
    task automatic offer_sample(input t_sample s, input bit typed, input t_hist_result want);
        t_hist_result res[$];
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.action <= s.action;
        in_if.pc     <= s.pc;
        in_if.in_gc  <= s.in_gc;
        in_if.in_ee  <= s.in_ee;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        // Transfer taken at this edge: advance the shadow table.
        histogram_step(s, res);
        if (typed) owed_results.push_back(want);
        else foreach (res[i]) owed_results.push_back(res[i]);
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Output side: random back-pressure, and check every transfer against the
    // oldest owed result.
    always @(posedge i_clk) begin
        t_hist_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (owed_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, got kind %0d slot %0d",
                             $time, out_if.kind, out_if.slot);
                end else begin
                    want = owed_results.pop_front();
                    check_field("kind",          64'(want.kind),
                                64'(out_if.kind));
                    check_field("status",        64'(want.status),
                                64'(out_if.status));
                    check_field("slot",          64'(want.slot),
                                64'(out_if.slot));
                    check_field("block_key",     64'(want.block_key),
                                64'(out_if.block_key));
                    check_field("sample_count",  64'(want.sample_count),
                                64'(out_if.sample_count));
                    check_field("gc_count",      64'(want.gc_count),
                                64'(out_if.gc_count));
                    check_field("ee_count",      64'(want.ee_count),
                                64'(out_if.ee_count));
                    check_field("dropped_count", 64'(want.dropped_count),
                                64'(out_if.dropped_count));
                    check_field("used_slots",    64'(want.used_slots),
                                64'(out_if.used_slots));
                    check_field("is_last",       64'(want.is_last),
                                64'(out_if.is_last));
                end
            end
            out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_sample      s;
        t_hist_result none;
        int           idle_plan [4];
        int           stall_plan [4];
        int           roll;

        // Drive every input to a known value from time zero.
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.action <= psbh_pkg::ACT_RECORD;
        in_if.pc     <= '0;
        in_if.in_gc  <= 1'b0;
        in_if.in_ee  <= 1'b0;

        err_count      = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        shadow_fill    = 0;
        shadow_drops   = '0;
        none           = '0;
        foreach (hot_blocks[i]) hot_blocks[i] = psbh_pkg::KEY_W'({$urandom, $urandom});

        // Directed table. The first six rows follow by hand from an empty
        // table; the rest are left to the predictor.
        plan.push_back('{'{psbh_pkg::ACT_DUMP, 64'd0, 1'b0, 1'b0}, 1'b1,
            result_of(psbh_pkg::KIND_SUMMARY, psbh_pkg::ST_HIT,
                      '0, '0, '0, '0, '0, '0, '0, 1'b1)});
        plan.push_back('{'{psbh_pkg::ACT_RECORD, 64'd0, 1'b0, 1'b0}, 1'b1,
            result_of(psbh_pkg::KIND_RECORD, psbh_pkg::ST_NEW,
                      5'd0, '0, 1, 0, 0, '0, 6'd1, 1'b1)});
        plan.push_back('{'{psbh_pkg::ACT_RECORD, {psbh_pkg::PC_W{1'b1}}, 1'b1, 1'b1}, 1'b1,
            result_of(psbh_pkg::KIND_RECORD, psbh_pkg::ST_NEW,
                      5'd1, {psbh_pkg::KEY_W{1'b1}}, 1, 1, 1, '0, 6'd2, 1'b1)});
        // Low six bits differ, same block: hits.
        plan.push_back('{'{psbh_pkg::ACT_RECORD, 64'd63, 1'b1, 1'b0}, 1'b1,
            result_of(psbh_pkg::KIND_RECORD, psbh_pkg::ST_HIT,
                      5'd0, '0, 2, 1, 0, '0, 6'd2, 1'b1)});
        plan.push_back('{'{psbh_pkg::ACT_RECORD, 64'hFFFF_FFFF_FFFF_FFC0, 1'b0, 1'b1}, 1'b1,
            result_of(psbh_pkg::KIND_RECORD, psbh_pkg::ST_HIT,
                      5'd1, {psbh_pkg::KEY_W{1'b1}}, 2, 1, 2, '0, 6'd2, 1'b1)});
        // Next block up from zero is a different slot.
        plan.push_back('{'{psbh_pkg::ACT_RECORD, 64'd64, 1'b1, 1'b1}, 1'b1,
            result_of(psbh_pkg::KIND_RECORD, psbh_pkg::ST_NEW,
                      5'd2, 58'd1, 1, 1, 1, '0, 6'd3, 1'b1)});
        plan.push_back('{'{psbh_pkg::ACT_RECORD, 64'h8000_0000_0000_0000, 1'b0, 1'b0},
                         1'b0, none});
        plan.push_back('{'{psbh_pkg::ACT_DUMP,   64'h0123_4567_89AB_CDEF, 1'b1, 1'b1},
                         1'b0, none});
        plan.push_back('{'{psbh_pkg::ACT_DUMP,   64'd0,                   1'b0, 1'b0},
                         1'b0, none});
        plan.push_back('{'{psbh_pkg::ACT_RECORD, 64'h0000_0000_0000_007F, 1'b1, 1'b0},
                         1'b0, none});
        plan.push_back('{'{psbh_pkg::ACT_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1},
                         1'b0, none});
        plan.push_back('{'{psbh_pkg::ACT_RECORD, 64'h5555_5555_5555_5555, 1'b1, 1'b0},
                         1'b0, none});
        plan.push_back('{'{psbh_pkg::ACT_RECORD, 64'hAAAA_AAAA_AAAA_AA80, 1'b1, 1'b1},
                         1'b0, none});
        plan.push_back('{'{psbh_pkg::ACT_RECORD, 64'h8000_0000_0000_003F, 1'b1, 1'b1},
                         1'b0, none});
        plan.push_back('{'{psbh_pkg::ACT_DUMP,   64'd0,                   1'b0, 1'b0},
                         1'b0, none});
        plan.push_back('{'{psbh_pkg::ACT_RECORD, 64'd0,                   1'b1, 1'b1},
                         1'b0, none});

        // Hold reset, then release it once.
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) offer_sample(plan[i].sample, plan[i].typed, plan[i].want);

        // Random part, one phase per idling pattern. Records mostly land on a
        // pool of hot blocks so hits pile up while the table fills past full;
        // the rest are stray PCs, most of which end up as drops, and a few dumps.
        idle_plan  = '{0, 60, 0, 21};
        stall_plan = '{0, 0, 60, 21};
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = idle_plan[ph];
            sink_stall_pct = stall_plan[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll    = $urandom_range(99);
                s.in_gc = 1'($urandom_range(1));
                s.in_ee = 1'($urandom_range(1));
                if (roll < 6) begin
                    s.action = psbh_pkg::ACT_DUMP;
                    s.pc     = {$urandom, $urandom};
                end else if (roll < 18) begin
                    s.action = psbh_pkg::ACT_RECORD;
                    s.pc     = {$urandom, $urandom};
                end else begin
                    s.action = psbh_pkg::ACT_RECORD;
                    s.pc     = {hot_blocks[$urandom_range(HOT_BLOCKS - 1)],
                                psbh_pkg::BLOCK_SHIFT'($urandom)};
                end
                offer_sample(s, 1'b0, none);
            end
        end
        in_if.valid <= 1'b0;

        // Wait for every owed result, then watch a little longer for extras.
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== pc_sample_block_histogram.f =====
+incdir+src
src/psbh_pkg.sv
src/psbh_in_if.sv
src/psbh_out_if.sv
src/psbh_slot_ram.sv
src/pc_sample_block_histogram.sv
sim/testbench.sv
